// ===== rtl/core/uqp_pkg.sv =====
// Shared types, character codes and helpers for the query string parser.
// No dependencies; imported by every module of the block.
package uqp_pkg;

  // Default longest token, counted with its terminator slot.
  localparam int TOKEN_CAP_DEF   = 256;
  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Escape tracker: nothing held, a '%' held, a '%' and one hex digit held.
  typedef enum logic [2:0] {
    PEND_NONE = 3'b001,
    PEND_PCT  = 3'b010,
    PEND_HEX  = 3'b100
  } pend_t;

  // Slot indexes within one queue entry; the last slot is the pair end.
  localparam int NUM_BYTE_SLOTS = 3;
  localparam int SLOT_END       = 3;

  // Everything one input byte causes: up to three bytes and a pair end.
  typedef struct packed {
    logic [NUM_BYTE_SLOTS-1:0][7:0] bytes;
    logic [NUM_BYTE_SLOTS:0]        mask;      // bit SLOT_END marks the pair end
    logic                           is_value;  // bytes belong to the value
    logic                           kept;      // pair kept flag for the end slot
  } q_entry_t;

  // Decode an ASCII hex digit: {valid, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/uqp_front.sv =====
// Front part: takes raw query bytes, tracks segment and escape state, and
// classifies each byte into one queue entry. Depends on uqp_pkg.
module uqp_front #(
  parameter int TOKEN_CAP = uqp_pkg::TOKEN_CAP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              query_valid,
  output logic              query_stall,
  input  logic [7:0]        query_byte,
  input  logic              end_of_query,
  input  logic              full,
  output logic              push,
  output uqp_pkg::q_entry_t push_entry
);
  import uqp_pkg::*;

  localparam int LEN_W = $clog2(TOKEN_CAP);
  localparam logic [LEN_W-1:0] CAP_M1 = LEN_W'(TOKEN_CAP - 1);

  // Segment state
  pend_t             pend, pend_next;
  logic [7:0]        held_hex, held_hex_next;
  logic [LEN_W-1:0]  tok_len, tok_len_next;
  logic              in_value, in_value_next;
  logic              key_nz, key_nz_next;
  logic              seg_open, seg_open_next;

  logic              accept;
  logic [4:0]        hex_c, hex_h;
  logic              is_amp, esc_pct_hex, esc_hex_hex, general;
  logic [NUM_BYTE_SLOTS-1:0]       want, take;
  logic [NUM_BYTE_SLOTS-1:0][7:0]  cand;
  logic [LEN_W-1:0]  run_len;
  logic              run_key_nz;
  logic              end_want;

  assign query_stall = full;
  assign accept      = query_valid && !full;

  assign hex_c       = hex_decode(query_byte);
  assign hex_h       = hex_decode(held_hex);
  assign is_amp      = (query_byte == CH_AMP);
  assign esc_pct_hex = !is_amp && (pend == PEND_PCT) && hex_c[4];
  assign esc_hex_hex = !is_amp && (pend == PEND_HEX) && hex_c[4] && hex_h[4];
  assign general     = !is_amp && !esc_pct_hex && !esc_hex_hex;

  // Build the candidate bytes in emission order: held '%', held digit, own byte
  always_comb begin
    want = '0;
    cand = '0;
    if (is_amp || general) begin
      want[0] = (pend != PEND_NONE);
      cand[0] = CH_PCT;
      want[1] = (pend == PEND_HEX);
      cand[1] = held_hex;
    end
    if (esc_pct_hex) begin
      // Token closes on the final byte with the escape half done
      want[0] = end_of_query;
      cand[0] = CH_PCT;
      want[1] = end_of_query;
      cand[1] = query_byte;
    end
    if (esc_hex_hex) begin
      want[2] = 1'b1;
      cand[2] = {hex_h[3:0], hex_c[3:0]};
    end
    if (general) begin
      case (query_byte)
        CH_PLUS: begin
          want[2] = 1'b1;
          cand[2] = CH_SPACE;
        end
        CH_PCT: begin
          // A fresh '%' on the final byte is flushed literally
          want[2] = end_of_query;
          cand[2] = CH_PCT;
        end
        CH_EQ: begin
          want[2] = in_value;
          cand[2] = CH_EQ;
        end
        default: begin
          want[2] = 1'b1;
          cand[2] = query_byte;
        end
      endcase
    end
  end

  // Apply the token length limit and track the key's first byte
  always_comb begin
    take       = '0;
    run_len    = tok_len;
    run_key_nz = key_nz;
    for (int i = 0; i < NUM_BYTE_SLOTS; i++) begin
      if (want[i] && run_len < CAP_M1) begin
        take[i] = 1'b1;
        if (!in_value && run_len == '0) begin
          run_key_nz = (cand[i] != 8'h00);
        end
        run_len = run_len + 1'b1;
      end
    end
  end

  assign end_want = is_amp ? seg_open : end_of_query;

  // Pack the entry for the back part
  always_comb begin
    push_entry.bytes    = cand;
    push_entry.mask     = {end_want, take};
    push_entry.is_value = in_value;
    push_entry.kept     = run_key_nz;
    push                = accept && ((|take) || end_want);
  end

  // Next segment state
  always_comb begin
    pend_next     = pend;
    held_hex_next = held_hex;
    tok_len_next  = run_len;
    in_value_next = in_value;
    key_nz_next   = run_key_nz;
    seg_open_next = 1'b1;
    if (is_amp || end_of_query) begin
      pend_next     = PEND_NONE;
      held_hex_next = '0;
      tok_len_next  = '0;
      in_value_next = 1'b0;
      key_nz_next   = 1'b0;
      seg_open_next = 1'b0;
    end else if (esc_pct_hex) begin
      pend_next     = PEND_HEX;
      held_hex_next = query_byte;
    end else if (esc_hex_hex) begin
      pend_next     = PEND_NONE;
      held_hex_next = '0;
    end else begin
      held_hex_next = '0;
      pend_next     = (query_byte == CH_PCT) ? PEND_PCT : PEND_NONE;
      if (query_byte == CH_EQ && !in_value) begin
        in_value_next = 1'b1;
        tok_len_next  = '0;
      end
    end
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= PEND_NONE;
      held_hex <= '0;
      tok_len  <= '0;
      in_value <= 1'b0;
      key_nz   <= 1'b0;
      seg_open <= 1'b0;
    end else if (accept) begin
      pend     <= pend_next;
      held_hex <= held_hex_next;
      tok_len  <= tok_len_next;
      in_value <= in_value_next;
      key_nz   <= key_nz_next;
      seg_open <= seg_open_next;
    end
  end

  // The final byte leaves the parser as after reset
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_query |=>
      pend == PEND_NONE && !seg_open && !in_value && tok_len == '0)
    else $error("segment state not cleared after final byte");

  // A token never grows past its limit
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    tok_len <= CAP_M1)
    else $error("token length over limit");

endmodule

// ===== rtl/core/uqp_queue.sv =====
// Short queue of classified entries between front and back parts.
// Depends on uqp_pkg for the entry type.
module uqp_queue #(
  parameter int DEPTH = uqp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uqp_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output uqp_pkg::q_entry_t head,
  output logic              empty
);
  import uqp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  q_entry_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue occupancy over depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/uqp_back.sv =====
// Back part: unpacks queue entries into single results and holds them in
// the output register. Depends on uqp_pkg.
module uqp_back (
  input  logic              clk,
  input  logic              rst,
  input  uqp_pkg::q_entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        item_kind,
  output logic              pair_kept,
  output logic              run_last
);
  import uqp_pkg::*;

  q_entry_t                  work;
  logic [NUM_BYTE_SLOTS:0]   work_mask, rem_mask;
  logic [1:0]                sel;
  logic                      out_free, emit, load;

  // Pick the earliest slot still to go
  always_comb begin
    sel = 2'(SLOT_END);
    for (int i = NUM_BYTE_SLOTS; i >= 0; i--) begin
      if (work_mask[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign rem_mask = work_mask & (work_mask - 1'b1);
  assign out_free = !result_valid || !result_stall;
  assign emit     = out_free && (|work_mask);
  assign load     = !empty && (work_mask == '0 || (emit && rem_mask == '0));
  assign pop      = load;

  // Hold the entry being unpacked
  always_ff @(posedge clk) begin
    if (rst) begin
      work_mask <= '0;
    end else if (load) begin
      work_mask <= head.mask;
    end else if (emit) begin
      work_mask <= rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      run_last <= (rem_mask == '0);
      if (sel == 2'(SLOT_END)) begin
        out_byte  <= 8'h00;
        item_kind <= KIND_END;
        pair_kept <= work.kept;
      end else begin
        out_byte  <= work.bytes[sel];
        item_kind <= work.is_value ? KIND_VALUE : KIND_KEY;
        pair_kept <= 1'b0;
      end
    end
  end

  a_end_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == KIND_END |-> out_byte == 8'h00)
    else $error("pair end carries a byte");

  a_kept_only_on_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind != KIND_END |-> !pair_kept)
    else $error("kept flag on a data byte");

endmodule

// ===== rtl/core/urlencoded_query_parser.sv =====
// Top level of the form-encoded query string parser: front, queue, back.
// Depends on uqp_pkg, uqp_front, uqp_queue and uqp_back.
//
// Input channel: one raw query byte per transaction (query_byte, with
// end_of_query on the final byte), handshake query_valid / query_stall.
// Output channel: one result per transaction (out_byte, item_kind,
// pair_kept, run_last), handshake result_valid / result_stall.
// The front accepts one byte every cycle while the queue has room; each
// byte gives zero to four results, and run_last marks the last of them.
// The back delivers one result per cycle while the receiver does not
// stall, so sustained rate is one byte per cycle for plain text; the
// extra results of an escape flush or pair end are soaked up by the
// QUEUE_DEPTH-entry queue.
// When the receiver stalls, the output register holds its result, the
// queue fills, and query_stall rises once the queue is full.
// Synchronous reset clears segment state, queue and output valid; the
// block is ready in the cycle after reset falls.
module urlencoded_query_parser #(
  parameter int TOKEN_CAP   = uqp_pkg::TOKEN_CAP_DEF,
  parameter int QUEUE_DEPTH = uqp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       query_valid,
  output logic       query_stall,
  input  logic [7:0] query_byte,
  input  logic       end_of_query,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] item_kind,
  output logic       pair_kept,
  output logic       run_last
);
  import uqp_pkg::*;

  q_entry_t push_entry, head;
  logic     push, full, pop, empty;

  // Classify incoming bytes
  uqp_front #(
    .TOKEN_CAP(TOKEN_CAP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .query_byte  (query_byte),
    .end_of_query(end_of_query),
    .full        (full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Decouple front and back
  uqp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Deliver results
  uqp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte    (out_byte),
    .item_kind   (item_kind),
    .pair_kept   (pair_kept),
    .run_last    (run_last)
  );

endmodule
